/* rtl/swmm_pkg.sv */
// swmm_pkg: shared types and constants of the sliding window min/max block
// no dependencies; imported by the front, the engine, the top level and the checker
`default_nettype none

package swmm_pkg;

  localparam int POS_BITS       = 32;  // position stamp, wraps modulo 2^32
  localparam int WS_BITS        = 11;  // window_size register
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam int REG_IDX_LSB    = 2;   // registers sit on 4-byte steps

  // register indexes
  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_MODE        = 1'b1;

  // mode codes
  localparam logic MODE_MIN = 1'b0;
  localparam logic MODE_MAX = 1'b1;

  localparam logic [WS_BITS-1:0] WINDOW_SIZE_RESET = WS_BITS'(1);

  typedef struct packed {
    logic [WS_BITS-1:0] window_size;
    logic               mode;
  } cfg_t;

  // control part of a queued item, the sample travels beside it
  typedef struct packed {
    logic                first_sample;
    logic                last_sample;
    logic [POS_BITS-1:0] pos;
  } item_ctl_t;

endpackage

`default_nettype wire

/* rtl/swmm_if.sv */
// swmm_sample_if / swmm_result_if: valid-ready channels of the block
// depends on nothing; used by the front, the engine and the top level
`default_nettype none

interface swmm_sample_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first_sample;
  logic                          last_sample;

  modport source (output valid, output sample, output first_sample,
                  output last_sample, input ready);
  modport sink   (input valid, input sample, input first_sample,
                  input last_sample, output ready);
endinterface

interface swmm_result_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_extreme;
  logic                          last_result;

  modport source (output valid, output window_extreme, output last_result,
                  input ready);
  modport sink   (input valid, input window_extreme, input last_result,
                  output ready);
endinterface

`default_nettype wire

/* rtl/swmm_ram.sv */
// swmm_ram: generic single-port-write, single-port-read RAM, registered read
// no dependencies
`default_nettype none

module swmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/swmm_front.sv */
// swmm_front: accepts sample beats and stamps each with its stream position
// depends on swmm_pkg and swmm_sample_if
`default_nettype none

module swmm_front #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  swmm_sample_if.sink                    sample_ch,
  output      logic                      push_valid,
  input  wire logic                      push_ready,
  output      logic [SAMPLE_BITS-1:0]    push_sample,
  output      swmm_pkg::item_ctl_t       push_ctl
);
  import swmm_pkg::*;

  logic [POS_BITS-1:0] position_counter;

  assign sample_ch.ready = push_ready;
  assign push_valid      = sample_ch.valid;
  assign push_sample     = sample_ch.sample;

  always_comb begin
    push_ctl.first_sample = sample_ch.first_sample;
    push_ctl.last_sample  = sample_ch.last_sample;
    push_ctl.pos          = position_counter;
  end

  // first_sample does not restart the position count
  always_ff @(posedge clk) begin
    if (rst) begin
      position_counter <= '0;
    end else if (sample_ch.valid && push_ready) begin
      position_counter <= position_counter + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/swmm_queue.sv */
// swmm_queue: two-entry fifo between the front and the deque engine
// no dependencies
`default_nettype none

module swmm_queue #(
  parameter int DATA_BITS = 66
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output      logic                 push_ready,
  input  wire logic [DATA_BITS-1:0] push_data,
  output      logic                 pop_valid,
  input  wire logic                 pop_ready,
  output      logic [DATA_BITS-1:0] pop_data
);

  logic [DATA_BITS-1:0] slots [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/swmm_engine.sv */
// swmm_engine: monotonic deque in a ring RAM, expires head and drops tail
// entries one per cycle, then appends and emits once the window has filled;
// depends on swmm_pkg, swmm_result_if and swmm_ram
`default_nettype none

module swmm_engine #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire swmm_pkg::cfg_t         cfg,
  input  wire logic                   q_valid,
  output      logic                   q_pop,
  input  wire logic [SAMPLE_BITS-1:0] q_sample,
  input  wire swmm_pkg::item_ctl_t    q_ctl,
  swmm_result_if.source               result_ch
);
  import swmm_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int OW = $clog2(WINDOW_MAX + 1);
  localparam int EW = SAMPLE_BITS + POS_BITS;
  localparam logic [POS_BITS-1:0] WMAX_POS = POS_BITS'(WINDOW_MAX);
  localparam logic [AW-1:0]       LAST_SLOT = AW'(WINDOW_MAX - 1);

  typedef enum logic [1:0] {S_IDLE, S_EXPIRE, S_TAIL, S_PUSH} state_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  state_t                  state;
  logic [AW-1:0]           head_pointer;
  logic [AW-1:0]           tail_pointer;
  logic [OW-1:0]           occupancy;
  logic [OW-1:0]           fill_count;
  logic [SAMPLE_BITS-1:0]  cur_sample;
  logic [POS_BITS-1:0]     cur_pos;
  logic                    cur_last;
  logic [SAMPLE_BITS-1:0]  head_val;
  logic                    out_valid;
  logic [SAMPLE_BITS-1:0]  out_extreme;
  logic                    out_last;

  logic                    ram_we;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [EW-1:0]           ram_rdata;
  logic [SAMPLE_BITS-1:0]  rd_val;
  logic [POS_BITS-1:0]     rd_pos;
  logic [POS_BITS-1:0]     ws_ext;
  logic [POS_BITS-1:0]     w_eff;
  logic [OW-1:0]           occ_m1;
  logic [OW-1:0]           fill_inc;
  logic                    expired;
  logic                    dominated;
  logic                    emit;
  logic                    out_free;

  swmm_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_MAX)
  ) u_deque_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_pointer),
    .wdata ({cur_sample, cur_pos}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val = ram_rdata[EW-1:POS_BITS];
  assign rd_pos = ram_rdata[POS_BITS-1:0];

  // zero acts as one, anything above the ring depth as the ring depth
  assign ws_ext = POS_BITS'(cfg.window_size);
  assign w_eff  = (ws_ext == '0) ? POS_BITS'(1) :
                  (ws_ext > WMAX_POS) ? WMAX_POS : ws_ext;

  assign occ_m1    = occupancy - 1'b1;
  assign expired   = (cur_pos - rd_pos) >= w_eff;
  assign dominated = (cfg.mode == MODE_MAX) ?
                     ($signed(rd_val) <= $signed(cur_sample)) :
                     ($signed(rd_val) >= $signed(cur_sample));
  assign fill_inc  = (POS_BITS'(fill_count) < w_eff) ? fill_count + 1'b1 : fill_count;
  assign emit      = !(POS_BITS'(fill_inc) < w_eff);
  assign out_free  = !out_valid || result_ch.ready;

  always_comb begin
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = head_pointer;
    case (state)
      S_IDLE: begin
        q_pop  = q_valid;
        ram_re = q_valid && !q_ctl.first_sample && (occupancy != '0);
      end
      S_EXPIRE: begin
        if (expired) begin
          ram_re    = (occ_m1 != '0);
          ram_raddr = ring_next(head_pointer);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ring_prev(tail_pointer);
        end
      end
      S_TAIL: begin
        ram_re    = dominated && (occ_m1 != '0);
        ram_raddr = ring_prev(ring_prev(tail_pointer));
      end
      S_PUSH: begin
        ram_we = !emit || out_free;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head_pointer <= '0;
      tail_pointer <= '0;
      occupancy    <= '0;
      fill_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if ((state == S_PUSH) && ram_we && emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_sample <= q_sample;
            cur_pos    <= q_ctl.pos;
            cur_last   <= q_ctl.last_sample;
            if (q_ctl.first_sample) begin
              head_pointer <= '0;
              tail_pointer <= '0;
              occupancy    <= '0;
              fill_count   <= '0;
            end
            state <= ram_re ? S_EXPIRE : S_PUSH;
          end
        end
        S_EXPIRE: begin
          if (expired) begin
            head_pointer <= ring_next(head_pointer);
            occupancy    <= occ_m1;
            if (occ_m1 == '0) begin
              state <= S_PUSH;
            end
          end else begin
            // surviving head keeps its value unless the tail scan empties the deque
            head_val <= rd_val;
            state    <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (dominated) begin
            tail_pointer <= ring_prev(tail_pointer);
            occupancy    <= occ_m1;
            if (occ_m1 == '0) begin
              state <= S_PUSH;
            end
          end else begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          // after expiry the deque holds fewer than window entries, never full
          if (ram_we) begin
            tail_pointer <= ring_next(tail_pointer);
            occupancy    <= occupancy + 1'b1;
            fill_count   <= fill_inc;
            if (emit) begin
              out_extreme <= (occupancy == '0) ? cur_sample : head_val;
              out_last    <= cur_last;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.window_extreme = out_extreme;
  assign result_ch.last_result    = out_last;

endmodule

`default_nettype wire

/* rtl/sliding_window_min_max.sv */
// sliding_window_min_max: top level, apb registers, front, queue and engine
// depends on swmm_pkg, swmm_if, swmm_front, swmm_queue, swmm_engine
//
//   channel     | dir  | beat carries                          | handshake
//   ------------+------+---------------------------------------+-------------
//   sample_ch   | in   | sample, first_sample, last_sample     | valid/ready
//   result_ch   | out  | window_extreme, last_result           | valid/ready
//   apb         | in   | window_size (0x0), mode (0x4)         | psel/penable
//
// a sample steps through idle, an expiry step per expired head entry and a
// tail step per dropped tail entry, checks of any surviving head and tail,
// then the append step; the single read port of the deque ram serialises them
// a two-beat queue lets the front take up to two samples while the engine works
// synchronous reset empties the deque and clears the position count at once
// a held result stalls only the final append step of the next sample
`default_nettype none

module sliding_window_min_max #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  swmm_sample_if.sink                              sample_ch,
  swmm_result_if.source                            result_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [swmm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [swmm_pkg::APB_DATA_BITS-1:0]  pwdata,
  output      logic [swmm_pkg::APB_DATA_BITS-1:0]  prdata,
  output      logic                                pready
);
  import swmm_pkg::*;

  localparam int QW = SAMPLE_BITS + $bits(item_ctl_t);

  cfg_t                   cfg;
  logic                   f_valid;
  logic                   f_ready;
  logic [SAMPLE_BITS-1:0] f_sample;
  item_ctl_t              f_ctl;
  logic                   q_valid;
  logic                   q_pop;
  logic [QW-1:0]          q_data;
  item_ctl_t              q_ctl;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_size <= WINDOW_SIZE_RESET;
      cfg.mode        <= MODE_MIN;
    end else if (psel && penable && pwrite) begin
      case (paddr[REG_IDX_LSB])
        REG_WINDOW_SIZE: cfg.window_size <= pwdata[WS_BITS-1:0];
        REG_MODE:        cfg.mode        <= pwdata[0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_IDX_LSB])
      REG_WINDOW_SIZE: prdata = APB_DATA_BITS'(cfg.window_size);
      REG_MODE:        prdata = APB_DATA_BITS'(cfg.mode);
      default:         prdata = '0;
    endcase
  end

  swmm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_ch   (sample_ch),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_sample (f_sample),
    .push_ctl    (f_ctl)
  );

  swmm_queue #(
    .DATA_BITS (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_sample, f_ctl}),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  assign q_ctl = q_data[$bits(item_ctl_t)-1:0];

  swmm_engine #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sample  (q_data[QW-1:$bits(item_ctl_t)]),
    .q_ctl     (q_ctl),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

/* rtl/swmm_checker.sv */
// swmm_checker: port-level assertions for sliding_window_min_max
// depends on swmm_pkg; bound to the top level at the end of this file
`default_nettype none

module swmm_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [SAMPLE_BITS-1:0]              out_extreme,
  input wire logic                                psel,
  input wire logic                                penable,
  input wire logic                                pwrite,
  input wire logic [swmm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input wire logic [swmm_pkg::APB_DATA_BITS-1:0]  pwdata,
  input wire logic [swmm_pkg::APB_DATA_BITS-1:0]  prdata
);
  import swmm_pkg::*;

  logic [31:0] in_count;
  logic [31:0] out_count;
  logic        ws_write;

  assign ws_write = psel && penable && pwrite && (paddr[REG_IDX_LSB] == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= '0;
      out_count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_count <= in_count + 1'b1;
      end
      if (out_valid && out_ready) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // every result beat needs a sample that has not yet given one
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |-> (in_count != out_count))
    else $error("result beat without an outstanding sample");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_extreme)))
    else $error("stalled result beat changed");

  a_window_readback: assert property (@(posedge clk) disable iff (rst)
    ws_write |=> ((paddr[REG_IDX_LSB] != REG_WINDOW_SIZE) ||
                  (prdata[WS_BITS-1:0] == $past(pwdata[WS_BITS-1:0]))))
    else $error("window_size readback differs from write");

endmodule

bind sliding_window_min_max swmm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample_ch.valid),
  .in_ready    (sample_ch.ready),
  .out_valid   (result_ch.valid),
  .out_ready   (result_ch.ready),
  .out_extreme (result_ch.window_extreme),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);

`default_nettype wire

/* dv/window_extreme_checker.sv */
`timescale 1ns / 100ps
// window_extreme_checker: watches the sample, result and register ports of the block,
// predicts every window min/max beat and compares it; needs swmm_pkg and swmm_if
module window_extreme_checker #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  swmm_sample_if                              smp,
  swmm_result_if                              res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [swmm_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [swmm_pkg::APB_DATA_BITS-1:0]  pwdata,
  input  logic [swmm_pkg::APB_DATA_BITS-1:0]  prdata,
  output int                                  failures,
  output int                                  pending
);
  import swmm_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] extreme;
    logic                          last;
  } window_out_t;

  window_out_t                   extreme_q[$];
  logic signed [SAMPLE_BITS-1:0] ring_val [WINDOW_MAX];
  logic [POS_BITS-1:0]           ring_pos [WINDOW_MAX];
  int unsigned                   head_idx, tail_idx, occupancy, filled;
  logic [POS_BITS-1:0]           stamp;
  logic [WS_BITS-1:0]            win_reg;
  logic                          mode_reg;
  int                            bad = 0;

  task automatic advance_window(input logic signed [SAMPLE_BITS-1:0] s,
                                input logic first, input logic last);
    int unsigned w;
    int unsigned prev;
    bit          dominated;
    w = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : win_reg);
    if (first) begin
      head_idx  = 0;
      tail_idx  = 0;
      occupancy = 0;
      filled    = 0;
    end
    // entries that fell out of the window ending at this sample
    while (occupancy > 0 && (stamp - ring_pos[head_idx]) >= POS_BITS'(w)) begin
      head_idx = (head_idx + 1) % WINDOW_MAX;
      occupancy--;
    end
    dominated = 1'b1;
    while (occupancy > 0 && dominated) begin
      prev = (tail_idx + WINDOW_MAX - 1) % WINDOW_MAX;
      dominated = (mode_reg == MODE_MAX) ? (ring_val[prev] <= s) : (ring_val[prev] >= s);
      if (dominated) begin
        tail_idx = prev;
        occupancy--;
      end
    end
    if (occupancy >= WINDOW_MAX) begin
      head_idx = (head_idx + 1) % WINDOW_MAX;
      occupancy--;
    end
    ring_val[tail_idx] = s;
    ring_pos[tail_idx] = stamp;
    tail_idx = (tail_idx + 1) % WINDOW_MAX;
    occupancy++;
    stamp = stamp + 1'b1;
    if (filled < w) filled++;
    if (filled >= w) extreme_q.push_back('{extreme: ring_val[head_idx], last: last});
  endtask

  always @(posedge clk) begin
    window_out_t           want;
    logic [APB_DATA_BITS-1:0] reg_want;
    if (rst) begin
      head_idx  = 0;
      tail_idx  = 0;
      occupancy = 0;
      filled    = 0;
      stamp     = '0;
      win_reg   = WINDOW_SIZE_RESET;
      mode_reg  = MODE_MIN;
      extreme_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if ((paddr >> REG_IDX_LSB) == REG_WINDOW_SIZE) win_reg = pwdata[WS_BITS-1:0];
          else if ((paddr >> REG_IDX_LSB) == REG_MODE) mode_reg = pwdata[0];
        end else begin
          reg_want = ((paddr >> REG_IDX_LSB) == REG_WINDOW_SIZE) ? APB_DATA_BITS'(win_reg)
                                                                 : APB_DATA_BITS'(mode_reg);
          if (prdata !== reg_want) begin
            $display("%0t: register read at 0x%0h, expected 0x%0h actual 0x%0h",
                     $time, paddr, reg_want, prdata);
            bad++;
          end
        end
      end
      if (smp.valid && smp.ready)
        advance_window(smp.sample, smp.first_sample, smp.last_sample);
      if (res.valid && res.ready) begin
        if (extreme_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %0d last %0b",
                   $time, res.window_extreme, res.last_result);
          bad++;
        end else begin
          want = extreme_q.pop_front();
          if (res.window_extreme !== want.extreme) begin
            $display("%0t: window_extreme mismatch, expected %0d actual %0d",
                     $time, want.extreme, res.window_extreme);
            bad++;
          end
          if (res.last_result !== want.last) begin
            $display("%0t: last_result mismatch, expected %0b actual %0b",
                     $time, want.last, res.last_result);
            bad++;
          end
        end
      end
    end
    failures <= bad;
    pending  <= extreme_q.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for sliding_window_min_max
// needs swmm_pkg, swmm_if, the block and window_extreme_checker
module tb_top;
  import swmm_pkg::*;

  localparam int WINDOW_MAX  = 1024;
  localparam int SAMPLE_BITS = 32;
  localparam int RAND_ITEMS  = 960;
  localparam int CALM_AFTER  = 800;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_NARROW,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_EDGES
  } value_shape_e;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel, penable, pwrite, pready;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;
  int                       failures, pending;
  bit                       calm = 1'b0;
  bit                       idle_on = 1'b1;
  int unsigned              cur_win = 1;

  swmm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
  swmm_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) res ();

  sliding_window_min_max #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (smp),
    .result_ch (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  window_extreme_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_extreme_check (
    .clk      (clk),
    .rst      (rst),
    .smp      (smp),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .failures (failures),
    .pending  (pending)
  );

  always #4 clk = ~clk;

  initial begin
    #8_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // result side: random stall bursts, none once the run is calm
  initial begin
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic reg_access(input logic wr, input logic idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_BITS'(idx) << REG_IDX_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (wr && idx == REG_WINDOW_SIZE) begin
      cur_win = (value[WS_BITS-1:0] == 0) ? 1 :
                ((value[WS_BITS-1:0] > WINDOW_MAX) ? WINDOW_MAX : value[WS_BITS-1:0]);
    end
  endtask

  task automatic put_sample(input logic signed [SAMPLE_BITS-1:0] v, input logic first,
                            input logic last);
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    smp.valid        <= 1'b1;
    smp.sample       <= v;
    smp.first_sample <= first;
    smp.last_sample  <= last;
    do @(posedge clk); while (!smp.ready);
  endtask

  // drain expected beats, then cover samples still in flight that give no result
  task automatic settle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3 * (2 * cur_win + 6) + 24) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input value_shape_e shape,
      input logic signed [SAMPLE_BITS-1:0] prev);
    case (shape)
      SHAPE_NARROW:  return $urandom_range(0, 8) - 4;
      SHAPE_RISING:  return prev + $urandom_range(0, 6);
      SHAPE_FALLING: return prev - $urandom_range(0, 6);
      SHAPE_EDGES: begin
        case ($urandom_range(0, 4))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return 0;
          3:       return -1;
          default: return $urandom;
        endcase
      end
      default:       return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned                   rand_items;
    int unsigned                   phase_left, seq_len, pick, i;
    bit                            large_done;
    bit                            restart;
    logic                          first, last;
    value_shape_e                  shape;
    logic signed [SAMPLE_BITS-1:0] level;

    rand_items = 0;
    large_done = 1'b0;
    rst              <= 1'b1;
    smp.valid        <= 1'b0;
    smp.sample       <= '0;
    smp.first_sample <= 1'b0;
    smp.last_sample  <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_access(1'b0, REG_WINDOW_SIZE, '0);
    reg_access(1'b0, REG_MODE, '0);

    // window size zero behaves as one
    reg_access(1'b1, REG_WINDOW_SIZE, 32'd0);
    reg_access(1'b1, REG_MODE, 32'(MODE_MIN));
    put_sample(S_MIN, 1'b1, 1'b0);
    put_sample(S_MAX, 1'b0, 1'b0);
    put_sample(0, 1'b0, 1'b0);
    put_sample(-1, 1'b0, 1'b1);
    settle();

    // max over three: ties, extremes, a last flag lost before the window fills
    reg_access(1'b1, REG_WINDOW_SIZE, 32'd3);
    reg_access(1'b1, REG_MODE, 32'(MODE_MAX));
    reg_access(1'b0, REG_WINDOW_SIZE, '0);
    reg_access(1'b0, REG_MODE, '0);
    put_sample(S_MAX, 1'b1, 1'b1);
    put_sample(S_MIN, 1'b0, 1'b0);
    put_sample(S_MAX, 1'b0, 1'b0);
    put_sample(S_MAX, 1'b0, 1'b0);
    put_sample(-1, 1'b0, 1'b0);
    put_sample(5, 1'b0, 1'b0);
    put_sample(5, 1'b0, 1'b0);
    put_sample(5, 1'b0, 1'b1);
    settle();

    // grow the window mid-stream, then shrink it so stale head entries go at once
    reg_access(1'b1, REG_WINDOW_SIZE, 32'd4);
    reg_access(1'b1, REG_MODE, 32'(MODE_MIN));
    put_sample(1, 1'b0, 1'b0);
    put_sample(2, 1'b0, 1'b0);
    put_sample(3, 1'b0, 1'b0);
    settle();
    reg_access(1'b1, REG_WINDOW_SIZE, 32'd2);
    put_sample(S_MAX, 1'b0, 1'b0);
    put_sample(-5, 1'b0, 1'b0);
    put_sample(-5, 1'b0, 1'b1);
    settle();
    reg_access(1'b1, REG_MODE, 32'(MODE_MAX));
    put_sample(3, 1'b0, 1'b0);
    put_sample(3, 1'b0, 1'b1);
    settle();

    while (rand_items < RAND_ITEMS) begin
      if (!large_done && rand_items >= 400) begin
        // oversized window clamps to the full ring; a short rising run stays below it
        large_done = 1'b1;
        idle_on = 1'b1;
        reg_access(1'b1, REG_WINDOW_SIZE, 32'd2047);
        reg_access(1'b1, REG_MODE, 32'(MODE_MIN));
        level = S_MIN;
        for (i = 0; i < 40; i++) begin
          put_sample(level, i == 0, 1'b0);
          level = level + $urandom_range(0, 3);
        end
        // a new floor empties the whole deque in one sample
        put_sample(S_MIN, 1'b0, 1'b0);
        for (i = 0; i < 8; i++) put_sample($urandom, 1'b0, i == 7);
        settle();
      end

      calm = (rand_items >= CALM_AFTER);
      idle_on = ($urandom_range(0, 9) < 7);
      pick = $urandom_range(0, 99);
      if (pick < 6) pick = 0;
      else if (pick < 50) pick = $urandom_range(1, 6);
      else if (pick < 85) pick = $urandom_range(7, 24);
      else pick = $urandom_range(25, 90);
      if ($urandom_range(0, 3) != 0) reg_access(1'b1, REG_WINDOW_SIZE, pick);
      if ($urandom_range(0, 2) != 0)
        reg_access(1'b1, REG_MODE, ($urandom_range(0, 1) != 0) ? 32'(MODE_MAX) : 32'(MODE_MIN));
      if ($urandom_range(0, 3) == 0) begin
        reg_access(1'b0, REG_WINDOW_SIZE, '0);
        reg_access(1'b0, REG_MODE, '0);
      end

      phase_left = $urandom_range(40, 160);
      restart = ($urandom_range(0, 2) != 0);
      while (phase_left > 0) begin
        // mostly sequences at least as long as the window, some no longer than it
        seq_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_win)
                                               : cur_win + $urandom_range(0, 2 * cur_win + 12);
        shape = value_shape_e'($urandom_range(0, 4));
        level = $urandom;
        for (i = 0; i < seq_len && phase_left > 0; i++) begin
          level = next_sample(shape, level);
          first = (i == 0) ? restart : ($urandom_range(0, 49) == 0);
          last  = (i == seq_len - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
          put_sample(level, first, last);
          phase_left--;
          rand_items++;
        end
        restart = 1'b1;
      end
      settle();
    end

    if (failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/swmm_pkg.sv
rtl/swmm_if.sv
rtl/swmm_ram.sv
rtl/swmm_front.sv
rtl/swmm_queue.sv
rtl/swmm_engine.sv
rtl/sliding_window_min_max.sv
rtl/swmm_checker.sv
dv/window_extreme_checker.sv
dv/tb_top.sv
